// ===== rtl/core/ttlfs_pkg.sv =====
// Shared types, constants and helpers for the TTL-bounded FIFO store.
package ttlfs_pkg;

    localparam int DEPTH_DEF    = 128;
    localparam int MAX_PAGE_DEF = 63;

    localparam int KEY_W   = 64;
    localparam int NAME_W  = 32;
    localparam int SIZE_W  = 31;
    localparam int TOPO_W  = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int PNUM_W  = 7;
    localparam int PLIM_W  = 6;
    localparam int SKIP_W  = PNUM_W + PLIM_W;

    localparam logic [TIME_W-1:0]  TTL_RESET         = 32'd86400;
    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 8'd100;

    typedef enum logic [1:0] {
        KIND_ADDED = 2'd0,
        KIND_DUP   = 2'd1,
        KIND_ENTRY = 2'd2,
        KIND_TOTAL = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_TTL = 1'b0,
        CFG_MAX = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [SIZE_W-1:0] size;
        logic [TOPO_W-1:0] topo;
        logic [TIME_W-1:0] created;
    } t_entry;

    // Age saturates at zero when time runs backwards.
    function automatic logic is_expired(input logic [TIME_W-1:0] created,
                                        input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] ttl);
        logic [TIME_W-1:0] age;
        age = (now >= created) ? (now - created) : '0;
        return age > ttl;
    endfunction

endpackage

// ===== rtl/core/ttl_fifo_store_with_paging_top.sv =====
// Top level of the TTL-bounded FIFO store with paged newest-first queries.
//
// Input channel (i_in_valid / o_in_stall) carries one item: mode 0 adds an
// entry, mode 1 asks for one page. Output channel (o_out_valid / i_out_stall)
// returns results; o_last marks the final result of an item. An add gives one
// result (added or duplicate, with the eviction count); a page gives up to
// page_limit entries, newest first, then a total of unexpired entries.
// Entries live in a single-port synchronous RAM of DEPTH words, one read or
// write per cycle with registered read data. The block works on one item
// at a time. An add first evicts expired entries from the oldest end, then
// evicts oldest entries for capacity, then scans the stored entries for its
// key; a duplicate ends the scan early, else the entry is appended. A page
// walks the stored entries newest first and ends with its total. A finished
// result sits in an output register; the walk pauses at each result to send
// while that register is full and stalled. Reset (synchronous, active low)
// empties the store and loads ttl 86400 s and capacity 100; RAM contents are
// not cleared, since only slots inside the stored count are ever read.
// Configuration writes take effect at once and are meant to land while the
// block is idle.
module ttl_fifo_store_with_paging_top #(
    parameter int DEPTH    = ttlfs_pkg::DEPTH_DEF,
    parameter int MAX_PAGE = ttlfs_pkg::MAX_PAGE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ttlfs_pkg::TIME_W-1:0]  i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [ttlfs_pkg::TIME_W-1:0]  i_now_seconds,
    input  logic [ttlfs_pkg::KEY_W-1:0]   i_entry_key,
    input  logic [ttlfs_pkg::NAME_W-1:0]  i_name_handle,
    input  logic [ttlfs_pkg::SIZE_W-1:0]  i_svg_size,
    input  logic [ttlfs_pkg::TOPO_W-1:0]  i_topo_handle,
    input  logic [ttlfs_pkg::PNUM_W-1:0]  i_page_number,
    input  logic [ttlfs_pkg::PLIM_W-1:0]  i_page_limit,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [ttlfs_pkg::KEY_W-1:0]   o_out_key,
    output logic [ttlfs_pkg::NAME_W-1:0]  o_out_name,
    output logic [ttlfs_pkg::SIZE_W-1:0]  o_out_size,
    output logic [ttlfs_pkg::TOPO_W-1:0]  o_out_topo,
    output logic [ttlfs_pkg::TIME_W-1:0]  o_out_created,
    output logic [ttlfs_pkg::COUNT_W-1:0] o_count_value,
    output logic                          o_last
);
    import ttlfs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot address
    localparam int CW = $clog2(DEPTH + 1);                // count 0..DEPTH
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;    // capacity compare
    localparam int SW = AW + 1;                           // oldest + offset

    typedef enum logic [3:0] {
        S_IDLE, S_EXP_RD, S_EXP_CHK, S_CAP, S_SCAN_RD, S_SCAN_CHK,
        S_ADD_OUT, S_PG_RD, S_PG_CHK, S_PG_TOT
    } t_state;

    t_state               r_state;
    logic [TIME_W-1:0]    r_ttl;
    logic [COUNT_W-1:0]   r_max;
    logic [AW-1:0]        r_oldest;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_evict;
    logic [CW-1:0]        r_total;
    logic [SKIP_W-1:0]    r_skip;
    logic [PLIM_W-1:0]    r_limit;
    logic [PLIM_W-1:0]    r_shown;
    t_kind                r_res_kind;
    t_entry               r_item;
    logic [TIME_W-1:0]    r_now;

    // entry RAM
    t_entry               r_mem [DEPTH];
    t_entry               r_rd;
    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_addr;
    logic [CW-1:0]        pos;
    logic [SW-1:0]        slot_sum;

    logic                 can_emit;
    logic                 out_load;
    logic                 rd_expired;
    logic [PLIM_W-1:0]    n_limit;
    logic [XW-1:0]        cap_lo, cap;
    logic [AW-1:0]        oldest_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign can_emit   = !o_out_valid || !i_out_stall;
    assign rd_expired = is_expired(r_rd.created, r_now, r_ttl);

    // output register loads a new transfer this cycle
    assign out_load = can_emit && ((r_state == S_ADD_OUT) || (r_state == S_PG_TOT) ||
                                   (r_state == S_PG_CHK && !rd_expired &&
                                    r_skip == '0 && r_shown < r_limit));

    // capacity clamp: 0 acts as 1, above DEPTH acts as DEPTH
    assign cap_lo = (r_max == '0) ? XW'(1) : XW'(r_max);
    assign cap    = (cap_lo > XW'(DEPTH)) ? XW'(DEPTH) : cap_lo;

    assign n_limit = (i_page_limit > PLIM_W'(MAX_PAGE)) ? PLIM_W'(MAX_PAGE)
                                                        : i_page_limit;

    assign oldest_inc = (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + AW'(1);

    // RAM port control; pages read one below the walking index
    always_comb begin
        mem_re = 1'b0;
        mem_we = 1'b0;
        pos    = r_idx;
        case (r_state)
            S_EXP_RD:  mem_re = (r_count != '0);
            S_SCAN_RD: begin
                mem_re = (r_idx != r_count);
                mem_we = (r_idx == r_count);
            end
            S_PG_RD: begin
                mem_re = (r_idx != '0);
                pos    = r_idx - CW'(1);
            end
            default: ;
        endcase
        slot_sum = SW'(r_oldest) + SW'(pos);
        if (slot_sum >= SW'(DEPTH)) begin
            slot_sum = slot_sum - SW'(DEPTH);
        end
        mem_addr = slot_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_item;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ttl       <= TTL_RESET;
            r_max       <= MAX_ENTRIES_RESET;
            r_oldest    <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TTL: r_ttl <= i_cfg_data;
                    CFG_MAX: r_max <= i_cfg_data[COUNT_W-1:0];
                endcase
            end

            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_now        <= i_now_seconds;
                        r_item       <= '{key: i_entry_key, name: i_name_handle,
                                          size: i_svg_size, topo: i_topo_handle,
                                          created: i_now_seconds};
                        r_limit      <= n_limit;
                        r_skip       <= SKIP_W'(i_page_number) * SKIP_W'(n_limit);
                        r_evict      <= '0;
                        r_total      <= '0;
                        r_shown      <= '0;
                        if (i_mode) begin
                            r_idx   <= r_count;
                            r_state <= S_PG_RD;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_EXP_RD;
                        end
                    end
                end
                S_EXP_RD: begin
                    r_state <= (r_count == '0) ? S_CAP : S_EXP_CHK;
                end
                S_EXP_CHK: begin
                    if (rd_expired) begin
                        r_oldest <= oldest_inc;
                        r_count  <= r_count - CW'(1);
                        r_evict  <= r_evict + CW'(1);
                        r_state  <= S_EXP_RD;
                    end else begin
                        r_state  <= S_CAP;
                    end
                end
                S_CAP: begin
                    if (r_count != '0 && XW'(r_count) >= cap) begin
                        r_oldest <= oldest_inc;
                        r_count  <= r_count - CW'(1);
                        r_evict  <= r_evict + CW'(1);
                    end else begin
                        r_idx    <= '0;
                        r_state  <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (r_idx == r_count) begin
                        // no match: append (RAM write happens this cycle)
                        r_count    <= r_count + CW'(1);
                        r_res_kind <= KIND_ADDED;
                        r_state    <= S_ADD_OUT;
                    end else begin
                        r_state    <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (r_rd.key == r_item.key) begin
                        r_res_kind <= KIND_DUP;
                        r_state    <= S_ADD_OUT;
                    end else begin
                        r_idx      <= r_idx + CW'(1);
                        r_state    <= S_SCAN_RD;
                    end
                end
                S_ADD_OUT: begin
                    if (can_emit) begin
                        o_kind        <= r_res_kind;
                        o_out_key     <= '0;
                        o_out_name    <= '0;
                        o_out_size    <= '0;
                        o_out_topo    <= '0;
                        o_out_created <= '0;
                        o_count_value <= COUNT_W'(r_evict);
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_PG_RD: begin
                    r_state <= (r_idx == '0) ? S_PG_TOT : S_PG_CHK;
                end
                S_PG_CHK: begin
                    if (rd_expired) begin
                        r_idx   <= r_idx - CW'(1);
                        r_state <= S_PG_RD;
                    end else if (r_skip != '0) begin
                        r_skip  <= r_skip - SKIP_W'(1);
                        r_total <= r_total + CW'(1);
                        r_idx   <= r_idx - CW'(1);
                        r_state <= S_PG_RD;
                    end else if (r_shown >= r_limit) begin
                        r_total <= r_total + CW'(1);
                        r_idx   <= r_idx - CW'(1);
                        r_state <= S_PG_RD;
                    end else if (can_emit) begin
                        o_kind        <= KIND_ENTRY;
                        o_out_key     <= r_rd.key;
                        o_out_name    <= r_rd.name;
                        o_out_size    <= r_rd.size;
                        o_out_topo    <= r_rd.topo;
                        o_out_created <= r_rd.created;
                        o_count_value <= '0;
                        o_last        <= 1'b0;
                        r_shown       <= r_shown + PLIM_W'(1);
                        r_total       <= r_total + CW'(1);
                        r_idx         <= r_idx - CW'(1);
                        r_state       <= S_PG_RD;
                    end
                end
                S_PG_TOT: begin
                    if (can_emit) begin
                        o_kind        <= KIND_TOTAL;
                        o_out_key     <= '0;
                        o_out_name    <= '0;
                        o_out_size    <= '0;
                        o_out_topo    <= '0;
                        o_out_created <= '0;
                        o_count_value <= COUNT_W'(r_total);
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the TTL-bounded FIFO store with paged queries.
`timescale 1ns / 100ps

module testbench;
    import ttlfs_pkg::*;

    // ---------------------------------------------------------------
    // Transfer records
    // ---------------------------------------------------------------
    typedef struct {
        logic               mode;
        logic [TIME_W-1:0]  now;
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name;
        logic [SIZE_W-1:0]  size;
        logic [TOPO_W-1:0]  topo;
        logic [PNUM_W-1:0]  pnum;
        logic [PLIM_W-1:0]  plim;
    } t_store_req;

    typedef struct {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name;
        logic [SIZE_W-1:0]  size;
        logic [TOPO_W-1:0]  topo;
        logic [TIME_W-1:0]  created;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_store_resp;

    localparam int RING     = DEPTH_DEF;
    localparam int REQ_CAP  = 512;
    localparam int RESP_CAP = 16384;

    // ---------------------------------------------------------------
    // DUT ports, all inputs driven to known values from time zero
    // ---------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = 1'b0;
    logic [TIME_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode = 1'b0;
    logic [TIME_W-1:0]    i_now_seconds = '0;
    logic [KEY_W-1:0]     i_entry_key = '0;
    logic [NAME_W-1:0]    i_name_handle = '0;
    logic [SIZE_W-1:0]    i_svg_size = '0;
    logic [TOPO_W-1:0]    i_topo_handle = '0;
    logic [PNUM_W-1:0]    i_page_number = '0;
    logic [PLIM_W-1:0]    i_page_limit = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_kind;
    logic [KEY_W-1:0]     o_out_key;
    logic [NAME_W-1:0]    o_out_name;
    logic [SIZE_W-1:0]    o_out_size;
    logic [TOPO_W-1:0]    o_out_topo;
    logic [TIME_W-1:0]    o_out_created;
    logic [COUNT_W-1:0]   o_count_value;
    logic                 o_last;

    ttl_fifo_store_with_paging_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Scoreboard state: request and expectation lists with read/write marks
    // ---------------------------------------------------------------
    t_store_req  pending_reqs[REQ_CAP];
    int          req_wr = 0;
    int          req_rd = 0;
    t_store_resp expected_resps[RESP_CAP];
    int          exp_wr = 0;
    int          exp_rd = 0;
    t_store_req  cur_req;

    int mismatches   = 0;
    int reqs_sent    = 0;
    int resps_seen   = 0;
    int cfg_writes   = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    bit calm_stretch = 0;

    // Mirror of the store: ring of entries, oldest at mirror_head.
    logic [KEY_W-1:0]   mirror_key  [RING];
    logic [NAME_W-1:0]  mirror_name [RING];
    logic [SIZE_W-1:0]  mirror_size [RING];
    logic [TOPO_W-1:0]  mirror_topo [RING];
    logic [TIME_W-1:0]  mirror_time [RING];
    logic [6:0]         mirror_head = '0;
    int                 mirror_count = 0;
    logic [TIME_W-1:0]  ttl_cfg = TTL_RESET;
    logic [COUNT_W-1:0] cap_cfg = MAX_ENTRIES_RESET;

    logic [KEY_W-1:0]   key_pool [16];
    logic [TIME_W-1:0]  sim_now = 32'd1000;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit stale(logic [TIME_W-1:0] created, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = (now >= created) ? now - created : '0;
        return age > ttl_cfg;
    endfunction

    function automatic t_store_resp bare_resp(t_kind k, int cnt, logic lst);
        t_store_resp r;
        r.kind = k;  r.key = '0;  r.name = '0;  r.size = '0;
        r.topo = '0; r.created = '0;
        r.count = cnt[COUNT_W-1:0];
        r.last = lst;
        return r;
    endfunction

    function automatic void expect_resp(input t_store_resp r);
        expected_resps[exp_wr] = r;
        exp_wr++;
    endfunction

    function automatic void add_req(input t_store_req rq);
        pending_reqs[req_wr] = rq;
        req_wr++;
    endfunction

    task automatic predict_store(input t_store_req rq);
        int cap, evicted, total, shown, skip, limit, i;
        bit dup;
        logic [6:0] s;
        t_store_resp r;
        if (rq.mode == 1'b0) begin
            cap = cap_cfg;
            if (cap == 0) cap = 1;
            if (cap > RING) cap = RING;
            evicted = 0;
            // expired entries leave first, then capacity evictions
            while (mirror_count > 0 && stale(mirror_time[mirror_head], rq.now)) begin
                mirror_head++;
                mirror_count--;
                evicted++;
            end
            while (mirror_count > 0 && mirror_count >= cap) begin
                mirror_head++;
                mirror_count--;
                evicted++;
            end
            dup = 0;
            for (i = 0; i < mirror_count; i++) begin
                s = mirror_head + i[6:0];
                if (mirror_key[s] == rq.key) dup = 1;
            end
            if (!dup) begin
                s = mirror_head + mirror_count[6:0];
                mirror_key[s]  = rq.key;
                mirror_name[s] = rq.name;
                mirror_size[s] = rq.size;
                mirror_topo[s] = rq.topo;
                mirror_time[s] = rq.now;
                mirror_count++;
            end
            expect_resp(bare_resp(dup ? KIND_DUP : KIND_ADDED, evicted, 1'b1));
        end else begin
            limit = rq.plim;
            if (limit > MAX_PAGE_DEF) limit = MAX_PAGE_DEF;
            skip = rq.pnum * limit;
            total = 0;
            shown = 0;
            // newest first, expired entries are invisible
            for (i = mirror_count; i > 0; i--) begin
                s = mirror_head + i[6:0] - 7'd1;
                if (!stale(mirror_time[s], rq.now)) begin
                    total++;
                    if (skip > 0) skip--;
                    else if (shown < limit) begin
                        r = bare_resp(KIND_ENTRY, 0, 1'b0);
                        r.key = mirror_key[s];
                        r.name = mirror_name[s];
                        r.size = mirror_size[s];
                        r.topo = mirror_topo[s];
                        r.created = mirror_time[s];
                        expect_resp(r);
                        shown++;
                    end
                end
            end
            expect_resp(bare_resp(KIND_TOTAL, total, 1'b1));
        end
    endtask

    // Mostly short gaps, a few long ones, with calm stretches of none.
    function automatic int idle_len();
        int r;
        if ($urandom_range(0, 99) < 4) calm_stretch = !calm_stretch;
        if (calm_stretch) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Driver: feeds the input channel from pending_reqs
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_store(cur_req);
                reqs_sent++;
            end
            if ((i_in_valid && !o_in_stall) || !i_in_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (req_rd < req_wr) begin
                    cur_req = pending_reqs[req_rd];
                    req_rd++;
                    i_mode        <= cur_req.mode;
                    i_now_seconds <= cur_req.now;
                    i_entry_key   <= cur_req.key;
                    i_name_handle <= cur_req.name;
                    i_svg_size    <= cur_req.size;
                    i_topo_handle <= cur_req.topo;
                    i_page_number <= cur_req.pnum;
                    i_page_limit  <= cur_req.plim;
                    i_in_valid    <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    // ---------------------------------------------------------------
    // Monitor: each result transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_store_resp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            resps_seen++;
            if (exp_rd == exp_wr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: unexpected result kind=%0d count=%0d last=%0b",
                             $realtime, o_kind, o_count_value, o_last);
            end else begin
                e = expected_resps[exp_rd];
                exp_rd++;
                if (o_kind !== e.kind || o_out_key !== e.key || o_out_name !== e.name ||
                    o_out_size !== e.size || o_out_topo !== e.topo ||
                    o_out_created !== e.created || o_count_value !== e.count ||
                    o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR %0t: exp kind=%0d key=%h name=%h size=%h topo=%h",
                                 $realtime, e.kind, e.key, e.name, e.size, e.topo);
                        $display("      created=%h count=%0d last=%0b", e.created,
                                 e.count, e.last);
                        $display("  got kind=%0d key=%h name=%h size=%h topo=%h",
                                 o_kind, o_out_key, o_out_name, o_out_size, o_out_topo);
                        $display("      created=%h count=%0d last=%0b", o_out_created,
                                 o_count_value, o_last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_add(input logic [TIME_W-1:0] now, input logic [KEY_W-1:0] key);
        t_store_req rq;
        rq.mode = 1'b0;  rq.now = now;  rq.key = key;
        rq.name = $urandom;  rq.size = SIZE_W'($urandom);  rq.topo = $urandom;
        rq.pnum = PNUM_W'($urandom);  rq.plim = PLIM_W'($urandom);
        add_req(rq);
    endtask

    task automatic queue_page(input logic [TIME_W-1:0] now, input int pnum, input int plim);
        t_store_req rq;
        rq.mode = 1'b1;  rq.now = now;  rq.key = {$urandom, $urandom};
        rq.name = $urandom;  rq.size = SIZE_W'($urandom);  rq.topo = $urandom;
        rq.pnum = pnum[PNUM_W-1:0];  rq.plim = plim[PLIM_W-1:0];
        add_req(rq);
    endtask

    // Written only with the store idle; the mirror follows at once.
    task automatic write_reg(input t_cfg_idx idx, input logic [TIME_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_TTL) ttl_cfg = val;
        else cap_cfg = val[COUNT_W-1:0];
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (req_rd < req_wr || i_in_valid || exp_rd < exp_wr)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 1)) return key_pool[$urandom_range(0, 15)];
        return {$urandom, $urandom};
    endfunction

    // Random mix: mostly adds with a small key pool for duplicates, some pages.
    task automatic queue_random(input int n);
        int k, pn, pl;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0 && sim_now > 50)
                sim_now -= $urandom_range(1, 40);        // clock stepping back
            else if ($urandom_range(0, 9) == 0)
                sim_now += $urandom_range(50, 300);
            else
                sim_now += $urandom_range(0, 12);
            if ($urandom_range(0, 99) < 65) begin
                queue_add(sim_now, pick_key());
            end else begin
                pn = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 127);
                case ($urandom_range(0, 19))
                    0:       pl = 0;
                    1, 2, 3: pl = $urandom_range(1, 63);
                    default: pl = $urandom_range(1, 8);
                endcase
                queue_page(sim_now, pn, pl);
            end
        end
    endtask

    function automatic logic [TIME_W-1:0] pick_ttl();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(5, 80);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int k;
        for (k = 0; k < 16; k++) key_pool[k] = {$urandom, $urandom};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: field extremes, duplicates, paging corners.
        queue_add(32'd1000, '0);
        pending_reqs[0].name = '0;  pending_reqs[0].size = '0;  pending_reqs[0].topo = '0;
        queue_add(32'd1000, '1);
        pending_reqs[1].name = '1;  pending_reqs[1].size = '1;  pending_reqs[1].topo = '1;
        queue_add(32'd1001, '0);                      // duplicate key
        queue_add(32'd1002, {$urandom, $urandom});
        queue_page(32'd1002, 0, 63);
        queue_page(32'd1002, 1, 1);
        queue_page(32'd1002, 127, 63);                // page far past the end
        queue_page(32'd1002, 0, 0);                   // limit zero: total only
        queue_add(32'd500, {$urandom, $urandom});     // clock stepping back
        queue_page(32'd1003, 0, 5);
        queue_add(32'd87400, {$urandom, $urandom});   // age equal to ttl stays
        queue_page(32'd87401, 0, 63);
        queue_add(32'd87401, {$urandom, $urandom});   // expired entries evicted
        queue_page(32'hFFFF_FFFF, 0, 63);             // everything expired
        queue_add(32'hFFFF_FFFF, {$urandom, $urandom});
        drain();

        // Smallest capacity, zero ttl.
        write_reg(CFG_TTL, '0);
        write_reg(CFG_MAX, 32'd1);
        sim_now = 32'd2000;
        queue_add(sim_now, key_pool[0]);
        queue_add(sim_now, key_pool[1]);
        queue_add(sim_now, key_pool[1]);
        queue_add(sim_now + 1, key_pool[2]);
        queue_page(sim_now + 1, 0, 3);
        drain();

        // Capacity register zero behaves as one.
        write_reg(CFG_MAX, 32'd0);
        sim_now = 32'd2100;
        queue_add(sim_now, key_pool[3]);
        queue_add(sim_now, key_pool[4]);
        queue_page(sim_now, 0, 2);
        drain();

        // Oversized capacity, ttl never expires; fill, then shrink capacity.
        write_reg(CFG_TTL, 32'hFFFF_FFFF);
        write_reg(CFG_MAX, 32'd200);
        queue_random(24);
        queue_page(sim_now, 0, 63);
        drain();
        write_reg(CFG_MAX, 32'd5);
        queue_page(sim_now, 0, 63);                   // old entries still there
        queue_add(sim_now, {$urandom, $urandom});
        queue_page(sim_now, 0, 63);
        drain();

        // Random phases with random settings.
        for (k = 0; k < 3; k++) begin
            write_reg(CFG_TTL, pick_ttl());
            write_reg(CFG_MAX, (k == 2) ? 32'd128 : $urandom_range(1, 12));
            queue_random(22);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (exp_wr != exp_rd) mismatches += exp_wr - exp_rd;
        $display("Covered %0d input transfers, %0d result transfers, %0d register writes.",
                 reqs_sent, resps_seen, cfg_writes);
        $display("Errors counted: %0d", mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #50ms;
        $display("Timeout with %0d results still expected", exp_wr - exp_rd);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ttlfs_pkg.sv
rtl/core/ttl_fifo_store_with_paging_top.sv
tb/testbench.sv
